@@ rtl/delta_input_bitstream_decoder_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the delta input bitstream decoder
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DELTA_INPUT_BITSTREAM_DECODER_TOP_ASSERT_SVH
`define DELTA_INPUT_BITSTREAM_DECODER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DIBD_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DIBD_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dibd_pkg.sv @@
// ----------------------------------------------------------------------------
// dibd_pkg
// Types, codes and the per-bit parse step of the delta bitstream decoder.
// ----------------------------------------------------------------------------
package dibd_pkg;

  localparam int unsigned INPUT_BYTES = 8;
  localparam logic [7:0]  IDX_LIMIT   = 8'(8 * INPUT_BYTES);

  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_INDEX = 2'd2;

  localparam logic MODE_HEADER  = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SIZE    = 2'd1;
  localparam logic [1:0] ERR_GAP     = 2'd2;
  localparam logic [1:0] ERR_OVERRUN = 2'd3;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] first_frame;
    logic [15:0]        bit_total;
    logic [7:0]         size_bytes;
    logic [7:0]         payload_byte;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] frame_number;
    logic [63:0]        frame_bits;
    logic [3:0]         vector_size;
    logic [1:0]         error_code;
    logic               last_of_run;
  } out_t;

  typedef struct packed {
    logic [63:0] vector;
    logic [31:0] last_frame;
    logic [31:0] next_frame;
    logic [15:0] bits_left;
    logic [1:0]  phase;
    logic [7:0]  index_accum;
    logic [2:0]  index_bits_seen;
    logic        new_value;
    logic        apply_changes;
    logic        frame_open;
    logic        message_dead;
  } dec_state_t;

  // parser state carried through the unrolled bit chain, plus what one bit emits
  typedef struct packed {
    dec_state_t  st;
    logic        done;
    logic        emit;
    logic        kind;
    logic [31:0] frame;
    logic [1:0]  code;
    logic [63:0] bits;
  } step_t;

  function automatic step_t parse_bit(step_t cur, logic b);
    step_t       s;
    logic [31:0] expect_f;
    logic [7:0]  idx;
    logic        apply;
    s        = cur;
    s.emit   = 1'b0;
    s.kind   = KIND_FRAME;
    s.code   = ERR_NONE;
    s.frame  = cur.st.next_frame;
    s.bits   = cur.st.vector;
    expect_f = cur.st.last_frame + 32'd1;
    idx      = cur.st.index_accum | (8'(b) << cur.st.index_bits_seen);
    apply    = cur.st.frame_open ? cur.st.apply_changes : (cur.st.next_frame == expect_f);
    if (!cur.done) begin
      if (cur.st.bits_left == 16'd0) begin
        // message used up; only an unfinished frame is an error
        s.done = 1'b1;
        if (cur.st.frame_open) begin
          s.st.message_dead = 1'b1;
          s.emit            = 1'b1;
          s.kind            = KIND_ERROR;
          s.code            = ERR_OVERRUN;
        end
      end else begin
        s.st.bits_left = cur.st.bits_left - 16'd1;
        unique case (cur.st.phase)
          PH_VALUE: begin
            s.st.new_value       = b;
            s.st.index_accum     = 8'd0;
            s.st.index_bits_seen = 3'd0;
            s.st.phase           = PH_INDEX;
          end
          PH_INDEX: begin
            s.st.index_accum = idx;
            if (cur.st.index_bits_seen == 3'd7) begin
              if (cur.st.apply_changes && (idx < IDX_LIMIT)) begin
                s.st.vector[idx[5:0]] = cur.st.new_value;
              end
              s.st.index_bits_seen = 3'd0;
              s.st.phase           = PH_FLAG;
            end else begin
              s.st.index_bits_seen = cur.st.index_bits_seen + 3'd1;
            end
          end
          default: begin
            if (!cur.st.frame_open && ($signed(cur.st.next_frame) > $signed(expect_f))) begin
              s.st.message_dead = 1'b1;
              s.emit            = 1'b1;
              s.kind            = KIND_ERROR;
              s.code            = ERR_GAP;
              s.done            = 1'b1;
            end else begin
              s.st.apply_changes = apply;
              s.st.frame_open    = 1'b1;
              if (b) begin
                s.st.phase = PH_VALUE;
              end else begin
                // end of frame: emit if it is the next one, else drop it
                s.st.phase = PH_FLAG;
                if (apply) begin
                  s.st.last_frame = cur.st.next_frame;
                  s.emit          = 1'b1;
                end
                s.st.next_frame = cur.st.next_frame + 32'd1;
                s.st.frame_open = 1'b0;
              end
            end
          end
        endcase
      end
    end
    return s;
  endfunction

endpackage

@@ rtl/delta_input_bitstream_decoder_top.sv @@
// ----------------------------------------------------------------------------
// delta_input_bitstream_decoder_top
// Delta-coded input stream decoder with a small result buffer and an output
// register.
// ----------------------------------------------------------------------------
// A header or payload byte is taken whole: all eight bits of a byte are
// parsed in one pass and the results it causes (up to eight) land in a
// result buffer, which the output register drains one per cycle while
// out_stall is low; the output rate is thus set by that single output
// register. The input is stalled only while buffered results would still be
// left after the current cycle. The synced register is written over the cfg
// channel, which is always ready; no clearing pass is needed after reset.
module delta_input_bitstream_decoder_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  dibd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output dibd_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);

  localparam int RES_DEPTH = 8;

  logic                 synced;
  dibd_pkg::dec_state_t st;
  dibd_pkg::dec_state_t st_next;
  logic [3:0]           size_in_use;
  logic [3:0]           size_in_use_next;

  dibd_pkg::out_t res_buf [RES_DEPTH];
  dibd_pkg::out_t res_next [RES_DEPTH];
  logic [3:0]     res_count;
  logic [3:0]     res_count_next;
  logic [3:0]     res_ptr;
  dibd_pkg::out_t load_data;

  logic pending;
  logic load;
  logic load_last;
  logic accept;

  assign cfg_ready = 1'b1;

  always_comb begin
    dibd_pkg::step_t cur;
    st_next          = st;
    size_in_use_next = size_in_use;
    res_count_next   = 4'd0;
    cur              = '0;
    cur.st           = st;
    for (int j = 0; j < RES_DEPTH; j++) begin
      res_next[j] = '0;
    end
    if (synced) begin
      if (in_data.mode == dibd_pkg::MODE_HEADER) begin
        if ((in_data.size_bytes == 8'd0) ||
            (in_data.size_bytes > 8'(dibd_pkg::INPUT_BYTES))) begin
          st_next.message_dead     = 1'b1;
          res_next[0].kind         = dibd_pkg::KIND_ERROR;
          res_next[0].frame_number = in_data.first_frame;
          res_next[0].frame_bits   = st.vector;
          res_next[0].vector_size  = size_in_use;
          res_next[0].error_code   = dibd_pkg::ERR_SIZE;
          res_count_next           = 4'd1;
        end else begin
          size_in_use_next = in_data.size_bytes[3:0];
          if (st.last_frame[31]) begin
            st_next.last_frame = in_data.first_frame - 32'sd1;
          end
          st_next.next_frame      = in_data.first_frame;
          st_next.bits_left       = in_data.bit_total;
          st_next.phase           = dibd_pkg::PH_FLAG;
          st_next.index_accum     = 8'd0;
          st_next.index_bits_seen = 3'd0;
          st_next.new_value       = 1'b0;
          st_next.apply_changes   = 1'b0;
          st_next.frame_open      = 1'b0;
          st_next.message_dead    = 1'b0;
        end
      end else if (!st.message_dead) begin
        for (int i = 0; i < 8; i++) begin
          cur = dibd_pkg::parse_bit(cur, in_data.payload_byte[i]);
          if (cur.emit) begin
            res_next[res_count_next[2:0]].kind         = cur.kind;
            res_next[res_count_next[2:0]].frame_number = cur.frame;
            res_next[res_count_next[2:0]].frame_bits   = cur.bits;
            res_next[res_count_next[2:0]].vector_size  = size_in_use;
            res_next[res_count_next[2:0]].error_code   = cur.code;
            res_count_next                             = res_count_next + 4'd1;
          end
        end
        st_next = cur.st;
      end
    end
  end

  assign pending   = (res_ptr != res_count);
  assign load      = pending && (!out_valid || !out_stall);
  assign load_last = (4'(res_ptr + 4'd1) == res_count);
  assign in_stall  = pending && !(load && load_last);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    load_data             = res_buf[res_ptr[2:0]];
    load_data.last_of_run = load_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      synced <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      synced <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.vector          <= '0;
      st.last_frame      <= '1;
      st.next_frame      <= '0;
      st.bits_left       <= '0;
      st.phase           <= dibd_pkg::PH_FLAG;
      st.index_accum     <= '0;
      st.index_bits_seen <= '0;
      st.new_value       <= 1'b0;
      st.apply_changes   <= 1'b0;
      st.frame_open      <= 1'b0;
      st.message_dead    <= 1'b1;
      size_in_use        <= 4'd1;
    end else if (accept) begin
      st          <= st_next;
      size_in_use <= size_in_use_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < RES_DEPTH; j++) begin
        res_buf[j] <= res_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= 4'd0;
      res_ptr   <= 4'd0;
    end else if (accept) begin
      // the entry being loaded this cycle is read before the overwrite
      res_count <= res_count_next;
      res_ptr   <= 4'd0;
    end else if (load) begin
      res_ptr <= res_ptr + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

@@ rtl/dibd_checker.sv @@
// ----------------------------------------------------------------------------
// dibd_checker
// Port-level checks for the delta bitstream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "delta_input_bitstream_decoder_top_assert.svh"

module dibd_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input dibd_pkg::out_t out_data,
  input logic           cfg_valid,
  input logic           cfg_ready
);

  `DIBD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result transaction changed")
  `DIBD_ASSERT_IMP(a_reset_idle, clk, rst, $past(rst), !out_valid, "result valid straight after reset")
  `DIBD_ASSERT_NXT(a_stall_busy, clk, rst, in_stall, out_valid, "input stalled with no result in flight")
  `DIBD_ASSERT_IMP(a_err_last, clk, rst, out_valid && (out_data.kind == dibd_pkg::KIND_ERROR), out_data.last_of_run, "error report not last of its run")
  `DIBD_ASSERT_IMP(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "configuration transaction refused")

endmodule

bind delta_input_bitstream_decoder_top dibd_checker u_dibd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
